// File: sv/ecc2d_pkg.sv
`timescale 1ns / 1ps
package ecc2d_pkg;

  // Fraction bits of the unit normal and of the restitution scale.
  localparam int N_BITS    = 28;
  localparam int REST_BITS = 14;
  localparam logic [15:0] REST_RESET = 16'd16384;

  // The larger offset magnitude is brought to this bit before the root.
  localparam int NORM_MSB = 29;

  localparam int WIDE_W = 80;
  typedef logic signed [WIDE_W-1:0] wide_t;

  localparam wide_t MAX32 = wide_t'(2147483647);
  localparam wide_t MIN32 = -MAX32 - wide_t'(1);

  // Per-item values that ride along with the arithmetic.
  typedef struct packed {
    logic signed [31:0] pvx;
    logic signed [31:0] pvy;
    logic signed [31:0] qvx;
    logic signed [31:0] qvy;
    logic [15:0]        mp;
    logic [15:0]        mq;
    logic               pfix;
    logic               qfix;
    logic               same;
    logic               sgx;
    logic               sgy;
  } keep_t;

  // Shift right by k, rounding half away from zero.
  function automatic wide_t rnd_shr(input wide_t x, input int k);
    wide_t half;
    wide_t mag;
    half = '0;
    half[k-1] = 1'b1;
    mag = x[WIDE_W-1] ? -x : x;
    mag = (mag + half) >>> k;
    return x[WIDE_W-1] ? -mag : mag;
  endfunction

  function automatic logic [31:0] sat32(input wide_t x);
    logic [31:0] r;
    if (x > MAX32) begin
      r = 32'h7fff_ffff;
    end else if (x < MIN32) begin
      r = 32'h8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  // Index of the highest set bit; zero when no bit is set.
  function automatic logic [5:0] msb_pos(input logic [32:0] m);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 33; i++) begin
      if (m[i]) begin
        p = 6'(i);
      end
    end
    return p;
  endfunction

endpackage

// File: sv/ecc2d_isqrt.sv
`timescale 1ns / 1ps
module ecc2d_isqrt #(
  parameter int IN_W   = 62,
  parameter int STEPS  = 3,
  parameter int SIDE_W = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_vld,
  input  logic [IN_W-1:0]     rad,
  input  logic [SIDE_W-1:0]   in_side,
  output logic                out_vld,
  output logic [IN_W/2-1:0]   root,
  output logic [SIDE_W-1:0]   out_side
);

  localparam int RW    = IN_W / 2;
  localparam int REM_W = RW + 2;
  localparam int NS    = (RW + STEPS - 1) / STEPS;

  logic [REM_W-1:0]  rem_q  [NS];
  logic [RW-1:0]     root_q [NS];
  logic [IN_W-1:0]   rad_q  [NS];
  logic              vld_q  [NS];
  logic [SIDE_W-1:0] side_q [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [REM_W-1:0]  rem_i;
    logic [RW-1:0]     root_i;
    logic [IN_W-1:0]   rad_i;
    logic              vld_i;
    logic [SIDE_W-1:0] side_i;
    logic [REM_W-1:0]  rem_o;
    logic [RW-1:0]     root_o;
    logic [IN_W-1:0]   rad_o;

    if (s == 0) begin : g_head
      assign rem_i  = '0;
      assign root_i = '0;
      assign rad_i  = rad;
      assign vld_i  = in_vld;
      assign side_i = in_side;
    end else begin : g_body
      assign rem_i  = rem_q[s-1];
      assign root_i = root_q[s-1];
      assign rad_i  = rad_q[s-1];
      assign vld_i  = vld_q[s-1];
      assign side_i = side_q[s-1];
    end

    // One result bit per step: bring down two radicand bits, try 4*root+1.
    always_comb begin
      logic [REM_W+1:0] acc;
      logic [REM_W+1:0] trial;
      rem_o  = rem_i;
      root_o = root_i;
      rad_o  = rad_i;
      for (int j = 0; j < STEPS; j++) begin
        if (s * STEPS + j < RW) begin
          acc   = {rem_o, rad_o[IN_W-1 -: 2]};
          trial = (REM_W + 2)'({root_o, 2'b01});
          rad_o = rad_o << 2;
          if (acc >= trial) begin
            rem_o  = REM_W'(acc - trial);
            root_o = {root_o[RW-2:0], 1'b1};
          end else begin
            rem_o  = REM_W'(acc);
            root_o = {root_o[RW-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[s] <= 1'b0;
      end else if (en) begin
        vld_q[s] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s]  <= rem_o;
        root_q[s] <= root_o;
        rad_q[s]  <= rad_o;
        side_q[s] <= side_i;
      end
    end
  end

  assign out_vld  = vld_q[NS-1];
  assign root     = root_q[NS-1];
  assign out_side = side_q[NS-1];

endmodule

// File: sv/ecc2d_div.sv
`timescale 1ns / 1ps
module ecc2d_div #(
  parameter int NUM_W  = 59,
  parameter int DEN_W  = 31,
  parameter int Q_W    = 29,
  parameter int STEPS  = 3,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  logic [NUM_W-1:0]  num_a,
  input  logic [NUM_W-1:0]  num_b,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_vld,
  output logic [Q_W-1:0]    quo_a,
  output logic [Q_W-1:0]    quo_b,
  output logic [SIDE_W-1:0] out_side
);

  localparam int CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;
  localparam int NS = (Q_W + STEPS - 1) / STEPS;

  logic [NUM_W-1:0]  ra_q   [NS];
  logic [NUM_W-1:0]  rb_q   [NS];
  logic [DEN_W-1:0]  den_q  [NS];
  logic [Q_W-1:0]    qa_q   [NS];
  logic [Q_W-1:0]    qb_q   [NS];
  logic              vld_q  [NS];
  logic [SIDE_W-1:0] side_q [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [NUM_W-1:0]  ra_i;
    logic [NUM_W-1:0]  rb_i;
    logic [DEN_W-1:0]  den_i;
    logic [Q_W-1:0]    qa_i;
    logic [Q_W-1:0]    qb_i;
    logic              vld_i;
    logic [SIDE_W-1:0] side_i;
    logic [NUM_W-1:0]  ra_o;
    logic [NUM_W-1:0]  rb_o;
    logic [Q_W-1:0]    qa_o;
    logic [Q_W-1:0]    qb_o;

    if (s == 0) begin : g_head
      assign ra_i   = num_a;
      assign rb_i   = num_b;
      assign den_i  = den;
      assign qa_i   = '0;
      assign qb_i   = '0;
      assign vld_i  = in_vld;
      assign side_i = in_side;
    end else begin : g_body
      assign ra_i   = ra_q[s-1];
      assign rb_i   = rb_q[s-1];
      assign den_i  = den_q[s-1];
      assign qa_i   = qa_q[s-1];
      assign qb_i   = qb_q[s-1];
      assign vld_i  = vld_q[s-1];
      assign side_i = side_q[s-1];
    end

    // Restoring division, quotient bits from the top; both lanes share den.
    always_comb begin
      logic [CW-1:0] dsh;
      int            bi;
      ra_o = ra_i;
      rb_o = rb_i;
      qa_o = qa_i;
      qb_o = qb_i;
      for (int j = 0; j < STEPS; j++) begin
        if (s * STEPS + j < Q_W) begin
          bi  = Q_W - 1 - s * STEPS - j;
          dsh = CW'(den_i) << bi;
          if (CW'(ra_o) >= dsh) begin
            ra_o     = NUM_W'(CW'(ra_o) - dsh);
            qa_o[bi] = 1'b1;
          end
          if (CW'(rb_o) >= dsh) begin
            rb_o     = NUM_W'(CW'(rb_o) - dsh);
            qb_o[bi] = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[s] <= 1'b0;
      end else if (en) begin
        vld_q[s] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ra_q[s]   <= ra_o;
        rb_q[s]   <= rb_o;
        den_q[s]  <= den_i;
        qa_q[s]   <= qa_o;
        qb_q[s]   <= qb_o;
        side_q[s] <= side_i;
      end
    end
  end

  assign out_vld  = vld_q[NS-1];
  assign quo_a    = qa_q[NS-1];
  assign quo_b    = qb_q[NS-1];
  assign out_side = side_q[NS-1];

endmodule

// File: sv/elastic_circle_collision_2d.sv
`timescale 1ns / 1ps
// Elastic collision of two circles, one pair per beat.
// Input channel: in_valid / in_stall with the two centres, velocities,
// masses and fixed flags. Output channel: out_valid / out_stall with the
// four new velocity components and same_point.
// Configuration: cfg_wr_en writes cfg_wr_data into the restitution register
// (unsigned Q2.14); write it only while no beat is in flight.
// The pipeline depth is set by the chain square root (11 stages) ->
// normal divider (10 stages) -> momentum divider (12 stages), plus the
// offset, projection, multiply, rounding and output registers.
// Throughput: one beat per cycle when not stalled; every stage is registered
// and the square root and both dividers are unrolled pipelines, three steps a stage.
// When out_stall holds a waiting result, the whole pipeline freezes and
// in_stall is raised in the same cycle; nothing is dropped or repeated.
// Reset (rst, synchronous) empties the pipeline and sets restitution to 1.0.
module elastic_circle_collision_2d (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] p_pos_x,
  input  logic signed [31:0] p_pos_y,
  input  logic signed [31:0] q_pos_x,
  input  logic signed [31:0] q_pos_y,
  input  logic signed [31:0] p_vel_x,
  input  logic signed [31:0] p_vel_y,
  input  logic signed [31:0] q_vel_x,
  input  logic signed [31:0] q_vel_y,
  input  logic [15:0]        p_mass,
  input  logic [15:0]        q_mass,
  input  logic               p_fixed,
  input  logic               q_fixed,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] p_new_vx,
  output logic signed [31:0] p_new_vy,
  output logic signed [31:0] q_new_vx,
  output logic signed [31:0] q_new_vy,
  output logic               same_point
);
  import ecc2d_pkg::*;

  localparam int STEPS    = 3;
  localparam int AX_W     = NORM_MSB + 1;
  localparam int SQ_W     = 2 * AX_W + 2;
  localparam int LEN_W    = SQ_W / 2;
  localparam int NQ_W     = N_BITS + 1;
  localparam int N_W      = NQ_W + 1;
  localparam int ND_NUM_W = AX_W + N_BITS + 1;
  localparam int PR_W     = 34;
  localparam int M_DEN_W  = 17;
  localparam int M_NUM_W  = 54;
  localparam int M_Q_W    = 36;
  localparam int MOM_W    = M_Q_W + 1;
  localparam int V_W      = 40;

  typedef struct packed {
    keep_t           k;
    logic [AX_W-1:0] ax;
    logic [AX_W-1:0] ay;
  } sq_side_t;

  typedef struct packed {
    keep_t                  k;
    logic signed [PR_W-1:0] pt;
    logic signed [PR_W-1:0] qt;
    logic signed [N_W-1:0]  nx;
    logic signed [N_W-1:0]  ny;
    logic                   sp;
    logic                   sq;
  } md_side_t;

  logic        adv;
  logic [15:0] restitution;

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      restitution <= REST_RESET;
    end else if (cfg_wr_en) begin
      restitution <= cfg_wr_data;
    end
  end

  // Valid bits of the stages outside the square root and dividers.
  logic v0, v1, v2, v3, v4, v5, v6, v7, v8, v9, v10, v11, v12, v13;
  logic vs, vd, vm;

  // Stage 0: input capture.
  keep_t              k0;
  logic signed [31:0] ppx0, ppy0, qpx0, qpy0;

  // Stage 1: offset magnitudes.
  keep_t              k1, k1_next;
  logic [32:0]        ax1, ay1;
  logic signed [32:0] dx, dy;

  assign dx = 33'(ppx0) - 33'(qpx0);
  assign dy = 33'(ppy0) - 33'(qpy0);

  always_comb begin
    k1_next      = k0;
    k1_next.sgx  = dx[32];
    k1_next.sgy  = dy[32];
    k1_next.same = (dx == 33'sd0) && (dy == 33'sd0);
  end

  // Stage 2: scale so the larger magnitude has its top bit at NORM_MSB.
  keep_t           k2;
  logic [AX_W-1:0] ax2, ay2;
  logic [32:0]     mx1;
  logic [5:0]      mpos;
  logic [32:0]     axs, ays;

  assign mx1  = (ax1 > ay1) ? ax1 : ay1;
  assign mpos = msb_pos(mx1);

  always_comb begin
    if (mpos > 6'(NORM_MSB)) begin
      axs = ax1 >> (mpos - 6'(NORM_MSB));
      ays = ay1 >> (mpos - 6'(NORM_MSB));
    end else begin
      axs = ax1 << (6'(NORM_MSB) - mpos);
      ays = ay1 << (6'(NORM_MSB) - mpos);
    end
  end

  // Stages 3 and 4: squared length.
  keep_t             k3, k4;
  logic [AX_W-1:0]   ax3, ay3, ax4, ay4;
  logic [2*AX_W-1:0] sqx3, sqy3;
  logic [SQ_W-2:0]   sq4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v0 <= in_valid;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // Fields in keep_t order; same and both signs start cleared.
      k0   <= {p_vel_x, p_vel_y, q_vel_x, q_vel_y, p_mass, q_mass,
               p_fixed, q_fixed, 3'b000};
      ppx0 <= p_pos_x;
      ppy0 <= p_pos_y;
      qpx0 <= q_pos_x;
      qpy0 <= q_pos_y;

      k1  <= k1_next;
      ax1 <= dx[32] ? (~dx + 33'd1) : dx;
      ay1 <= dy[32] ? (~dy + 33'd1) : dy;

      k2  <= k1;
      ax2 <= axs[AX_W-1:0];
      ay2 <= ays[AX_W-1:0];

      k3   <= k2;
      ax3  <= ax2;
      ay3  <= ay2;
      sqx3 <= (2*AX_W)'(ax2) * (2*AX_W)'(ax2);
      sqy3 <= (2*AX_W)'(ay2) * (2*AX_W)'(ay2);

      k4  <= k3;
      ax4 <= ax3;
      ay4 <= ay3;
      sq4 <= (SQ_W-1)'(sqx3) + (SQ_W-1)'(sqy3);
    end
  end

  // Length of the scaled offset.
  sq_side_t         sq_in_side, sq_out_side;
  logic [LEN_W-1:0] len_s;

  assign sq_in_side.k  = k4;
  assign sq_in_side.ax = ax4;
  assign sq_in_side.ay = ay4;

  ecc2d_isqrt #(
    .IN_W   (SQ_W),
    .STEPS  (STEPS),
    .SIDE_W ($bits(sq_side_t))
  ) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_vld   (v4),
    .rad      ({1'b0, sq4}),
    .in_side  (sq_in_side),
    .out_vld  (vs),
    .root     (len_s),
    .out_side (sq_out_side)
  );

  // Unit normal magnitudes: round(a * 2^28 / len).
  logic [ND_NUM_W-1:0] ndx_num, ndy_num;
  logic [NQ_W-1:0]     qnx, qny;
  keep_t               kd;

  assign ndx_num = (ND_NUM_W'(sq_out_side.ax) << N_BITS) + ND_NUM_W'(len_s[LEN_W-1:1]);
  assign ndy_num = (ND_NUM_W'(sq_out_side.ay) << N_BITS) + ND_NUM_W'(len_s[LEN_W-1:1]);

  ecc2d_div #(
    .NUM_W  (ND_NUM_W),
    .DEN_W  (LEN_W),
    .Q_W    (NQ_W),
    .STEPS  (STEPS),
    .SIDE_W ($bits(keep_t))
  ) u_ndiv (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_vld   (vs),
    .num_a    (ndx_num),
    .num_b    (ndy_num),
    .den      (len_s),
    .in_side  (sq_out_side.k),
    .out_vld  (vd),
    .quo_a    (qnx),
    .quo_b    (qny),
    .out_side (kd)
  );

  // Stage 5: signed normal. Stages 6 and 7: normal and tangent projections.
  keep_t                   k5, k6, k7;
  logic signed [N_W-1:0]   nx5, ny5, nx6, ny6, nx7, ny7;
  logic signed [N_W-1:0]   nxu, nyu;
  logic signed [61:0]      pxnx6, pyny6, pxny6, pynx6;
  logic signed [61:0]      qxnx6, qyny6, qxny6, qynx6;
  logic signed [PR_W-1:0]  pn7, qn7, pt7, qt7;
  wide_t                   pn_w, qn_w, pt_w, qt_w;

  assign nxu = signed'({1'b0, qnx});
  assign nyu = signed'({1'b0, qny});

  assign pn_w = rnd_shr(wide_t'(pxnx6) + wide_t'(pyny6), N_BITS);
  assign qn_w = rnd_shr(wide_t'(qxnx6) + wide_t'(qyny6), N_BITS);
  // The tangent is (-ny, nx).
  assign pt_w = rnd_shr(wide_t'(pynx6) - wide_t'(pxny6), N_BITS);
  assign qt_w = rnd_shr(wide_t'(qynx6) - wide_t'(qxny6), N_BITS);

  // Stages 8 and 9: momentum exchange numerators.
  keep_t                     k8, k9;
  logic [15:0]               mpe, mqe;
  logic signed [M_DEN_W-1:0] dm, ndm;
  logic signed [M_DEN_W:0]   mp2s, mq2s;
  logic [M_DEN_W-1:0]        den8, den9;
  logic signed [51:0]        pa8, pb8, qa8, qb8;
  logic signed [52:0]        nump9, numq9;
  logic signed [PR_W-1:0]    pt8, qt8, pt9, qt9;
  logic signed [N_W-1:0]     nx8, ny8, nx9, ny9;

  // Both masses zero counts as two unit masses.
  assign mpe  = ((k7.mp == 16'd0) && (k7.mq == 16'd0)) ? 16'd1 : k7.mp;
  assign mqe  = ((k7.mp == 16'd0) && (k7.mq == 16'd0)) ? 16'd1 : k7.mq;
  assign dm   = signed'({1'b0, mpe}) - signed'({1'b0, mqe});
  assign ndm  = -dm;
  assign mp2s = signed'({1'b0, mpe, 1'b0});
  assign mq2s = signed'({1'b0, mqe, 1'b0});

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
      v9 <= 1'b0;
    end else if (adv) begin
      v5 <= vd;
      v6 <= v5;
      v7 <= v6;
      v8 <= v7;
      v9 <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k5  <= kd;
      nx5 <= kd.sgx ? -nxu : nxu;
      ny5 <= kd.sgy ? -nyu : nyu;

      k6    <= k5;
      nx6   <= nx5;
      ny6   <= ny5;
      pxnx6 <= 62'(k5.pvx) * 62'(nx5);
      pyny6 <= 62'(k5.pvy) * 62'(ny5);
      pxny6 <= 62'(k5.pvx) * 62'(ny5);
      pynx6 <= 62'(k5.pvy) * 62'(nx5);
      qxnx6 <= 62'(k5.qvx) * 62'(nx5);
      qyny6 <= 62'(k5.qvy) * 62'(ny5);
      qxny6 <= 62'(k5.qvx) * 62'(ny5);
      qynx6 <= 62'(k5.qvy) * 62'(nx5);

      k7  <= k6;
      nx7 <= nx6;
      ny7 <= ny6;
      pn7 <= pn_w[PR_W-1:0];
      qn7 <= qn_w[PR_W-1:0];
      pt7 <= pt_w[PR_W-1:0];
      qt7 <= qt_w[PR_W-1:0];

      k8   <= k7;
      nx8  <= nx7;
      ny8  <= ny7;
      pt8  <= pt7;
      qt8  <= qt7;
      den8 <= M_DEN_W'(mpe) + M_DEN_W'(mqe);
      pa8  <= 52'(pn7) * 52'(dm);
      pb8  <= 52'(qn7) * 52'(mq2s);
      qa8  <= 52'(qn7) * 52'(ndm);
      qb8  <= 52'(pn7) * 52'(mp2s);

      k9    <= k8;
      nx9   <= nx8;
      ny9   <= ny8;
      pt9   <= pt8;
      qt9   <= qt8;
      den9  <= den8;
      nump9 <= 53'(pa8) + 53'(pb8);
      numq9 <= 53'(qa8) + 53'(qb8);
    end
  end

  // Momentum division, rounded half away from zero on the magnitude.
  logic [52:0]          magp, magq;
  logic [M_NUM_W-1:0]   mdp_num, mdq_num;
  logic [M_Q_W-1:0]     qpm, qqm;
  md_side_t             md_in_side, md_out_side;

  assign magp    = nump9[52] ? 53'(-nump9) : 53'(nump9);
  assign magq    = numq9[52] ? 53'(-numq9) : 53'(numq9);
  assign mdp_num = M_NUM_W'(magp) + M_NUM_W'(den9[M_DEN_W-1:1]);
  assign mdq_num = M_NUM_W'(magq) + M_NUM_W'(den9[M_DEN_W-1:1]);

  assign md_in_side.k  = k9;
  assign md_in_side.pt = pt9;
  assign md_in_side.qt = qt9;
  assign md_in_side.nx = nx9;
  assign md_in_side.ny = ny9;
  assign md_in_side.sp = nump9[52];
  assign md_in_side.sq = numq9[52];

  ecc2d_div #(
    .NUM_W  (M_NUM_W),
    .DEN_W  (M_DEN_W),
    .Q_W    (M_Q_W),
    .STEPS  (STEPS),
    .SIDE_W ($bits(md_side_t))
  ) u_mdiv (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_vld   (v9),
    .num_a    (mdp_num),
    .num_b    (mdq_num),
    .den      (den9),
    .in_side  (md_in_side),
    .out_vld  (vm),
    .quo_a    (qpm),
    .quo_b    (qqm),
    .out_side (md_out_side)
  );

  // Stage 10: signed momenta. Stages 11 to 13: rebuild and restitution.
  keep_t                   k10, k11, k12, k13;
  logic signed [MOM_W-1:0] pmu, qmu;
  logic signed [MOM_W-1:0] pm10, qm10;
  logic signed [PR_W-1:0]  pt10, qt10;
  logic signed [N_W-1:0]   nx10, ny10;
  logic signed [66:0]      pa11, pb11, pc11, pd11;
  logic signed [66:0]      qa11, qb11, qc11, qd11;
  logic signed [V_W-1:0]   vpx12, vpy12, vqx12, vqy12;
  wide_t                   vpx_w, vpy_w, vqx_w, vqy_w;
  logic signed [16:0]      rest_s;
  logic signed [56:0]      spx13, spy13, sqx13, sqy13;
  wide_t                   opx_w, opy_w, oqx_w, oqy_w;

  assign pmu = signed'({1'b0, qpm});
  assign qmu = signed'({1'b0, qqm});

  assign vpx_w = rnd_shr(wide_t'(pb11) - wide_t'(pa11), N_BITS);
  assign vpy_w = rnd_shr(wide_t'(pc11) + wide_t'(pd11), N_BITS);
  assign vqx_w = rnd_shr(wide_t'(qb11) - wide_t'(qa11), N_BITS);
  assign vqy_w = rnd_shr(wide_t'(qc11) + wide_t'(qd11), N_BITS);

  assign rest_s = signed'({1'b0, restitution});

  assign opx_w = rnd_shr(wide_t'(spx13), REST_BITS);
  assign opy_w = rnd_shr(wide_t'(spy13), REST_BITS);
  assign oqx_w = rnd_shr(wide_t'(sqx13), REST_BITS);
  assign oqy_w = rnd_shr(wide_t'(sqy13), REST_BITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      v10       <= 1'b0;
      v11       <= 1'b0;
      v12       <= 1'b0;
      v13       <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v10       <= vm;
      v11       <= v10;
      v12       <= v11;
      v13       <= v12;
      out_valid <= v13;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k10  <= md_out_side.k;
      pt10 <= md_out_side.pt;
      qt10 <= md_out_side.qt;
      nx10 <= md_out_side.nx;
      ny10 <= md_out_side.ny;
      pm10 <= md_out_side.sp ? -pmu : pmu;
      qm10 <= md_out_side.sq ? -qmu : qmu;

      // x uses -ny*t + nx*m, y uses nx*t + ny*m.
      k11  <= k10;
      pa11 <= 67'(ny10) * 67'(pt10);
      pb11 <= 67'(nx10) * 67'(pm10);
      pc11 <= 67'(nx10) * 67'(pt10);
      pd11 <= 67'(ny10) * 67'(pm10);
      qa11 <= 67'(ny10) * 67'(qt10);
      qb11 <= 67'(nx10) * 67'(qm10);
      qc11 <= 67'(nx10) * 67'(qt10);
      qd11 <= 67'(ny10) * 67'(qm10);

      k12   <= k11;
      vpx12 <= vpx_w[V_W-1:0];
      vpy12 <= vpy_w[V_W-1:0];
      vqx12 <= vqx_w[V_W-1:0];
      vqy12 <= vqy_w[V_W-1:0];

      k13   <= k12;
      spx13 <= 57'(vpx12) * 57'(rest_s);
      spy13 <= 57'(vpy12) * 57'(rest_s);
      sqx13 <= 57'(vqx12) * 57'(rest_s);
      sqy13 <= 57'(vqy12) * 57'(rest_s);

      same_point <= k13.same;
      if (k13.same || k13.pfix) begin
        p_new_vx <= k13.pvx;
        p_new_vy <= k13.pvy;
      end else begin
        p_new_vx <= sat32(opx_w);
        p_new_vy <= sat32(opy_w);
      end
      if (k13.same || k13.qfix) begin
        q_new_vx <= k13.qvx;
        q_new_vy <= k13.qvy;
      end else begin
        q_new_vx <= sat32(oqx_w);
        q_new_vy <= sat32(oqy_w);
      end
    end
  end

  a_reset_empties: assert property (@(posedge clk)
    rst |=> (!out_valid && !v0 && !v13))
    else $error("pipeline not empty after reset");

  a_last_stage_drains: assert property (@(posedge clk) disable iff (rst)
    (v13 && adv) |=> out_valid)
    else $error("beat in last stage did not reach the output register");

  a_same_point_passes: assert property (@(posedge clk) disable iff (rst)
    (v13 && adv && k13.same) |=>
      (same_point && p_new_vx == $past(k13.pvx) && q_new_vy == $past(k13.qvy)))
    else $error("coincident centres did not pass velocities through");

endmodule
